// ----- hdl/vap_pkg.sv -----
`default_nettype none
package vap_pkg;

  localparam int VOX_W      = 32;
  localparam int ACC_W      = 48;
  localparam int OUT_X_W    = 10;
  localparam int OUT_Z_W    = 12;
  localparam int METHOD_W   = 2;
  localparam int ROW_REG_W  = 11;
  localparam int COL_REG_W  = 13;
  localparam int SLC_REG_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  // Wide enough for any clamped size limit up to 65536.
  localparam int SIZE_W     = 17;

  typedef enum logic [METHOD_W-1:0] {
    METHOD_MAX  = 2'd0,
    METHOD_MIN  = 2'd1,
    METHOD_MEAN = 2'd2,
    METHOD_SUM  = 2'd3
  } method_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METHOD        = 2'd0,
    REG_ROW_LENGTH    = 2'd1,
    REG_COLUMN_HEIGHT = 2'd2,
    REG_SLICE_COUNT   = 2'd3
  } reg_index_t;

  typedef struct packed {
    method_t                method;
    logic [ROW_REG_W-1:0]   row_length;
    logic [COL_REG_W-1:0]   column_height;
    logic [SLC_REG_W-1:0]   slice_count;
  } cfg_t;

  // One entry of the divider chain. For mean results the word holds the
  // dividend magnitude, which shifts out as quotient bits shift in.
  typedef struct packed {
    logic                 valid;
    logic                 div;
    logic                 neg;
    logic [ACC_W-1:0]     word;
    logic [COL_REG_W-1:0] rem;
    logic [COL_REG_W-1:0] dvsr;
    logic [OUT_X_W-1:0]   x;
    logic [OUT_Z_W-1:0]   z;
    logic                 done;
  } cell_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > limit) begin
      r = limit;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/volume_axis_projection_core.sv -----
`default_nettype none
// Projection of a voxel volume along its y axis (max, min, mean or sum).
//
// Input channel: one voxel word per handshake (in_valid/in_ready), in memory
// order with x fastest, then y, then z. Output channel: one word per column
// (out_valid/out_ready) carrying the projected value, its x and z position,
// and volume_done on the last column of the volume. Words leave z outer,
// x inner.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (method, row_length, column_height, slice_count); write only while idle.
// A new voxel is taken only after the previous one is written back to the
// column accumulator memory (one registered read, then the update and
// write-back); a column's last voxel also waits there until the chain moves.
// A column's last voxel passes the memory read register, the update, the
// 48 cells of the restoring divider chain and the output register. Every
// result goes through the chain, so results stay in order whatever the method.
// Stall: when the receiver holds out_ready low with a word waiting, the
// chain freezes; voxels keep being accepted until a new column end needs
// the chain. Reset clears the positions, the chain and the output valid;
// the accumulator memory needs no clearing since each column starts by
// loading its first voxel.
module volume_axis_projection_core
  import vap_pkg::*;
#(
  parameter int MAX_ROW    = 1024,
  parameter int MAX_COLUMN = 4096,
  parameter int MAX_SLICES = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [VOX_W-1:0]       voxel_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ACC_W-1:0]            projected_value,
  output logic [OUT_X_W-1:0]          out_x,
  output logic [OUT_Z_W-1:0]          out_z,
  output logic                        volume_done
);

  cfg_t  cfg;
  logic  advance;
  cell_t chain [ACC_W+1];
  cell_t tail;

  // Configuration registers, written by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.method        <= METHOD_MAX;
      cfg.row_length    <= ROW_REG_W'(1);
      cfg.column_height <= COL_REG_W'(1);
      cfg.slice_count   <= SLC_REG_W'(1);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_METHOD:        cfg.method        <= method_t'(cfg_data[METHOD_W-1:0]);
        REG_ROW_LENGTH:    cfg.row_length    <= cfg_data[ROW_REG_W-1:0];
        REG_COLUMN_HEIGHT: cfg.column_height <= cfg_data[COL_REG_W-1:0];
        REG_SLICE_COUNT:   cfg.slice_count   <= cfg_data[SLC_REG_W-1:0];
        default:           cfg.method        <= cfg.method;
      endcase
    end
  end

  // The whole chain moves one step whenever the output register is free or
  // being emptied this cycle.
  assign advance = !out_valid || out_ready;

  vap_column_unit #(
    .MAX_ROW    (MAX_ROW),
    .MAX_COLUMN (MAX_COLUMN),
    .MAX_SLICES (MAX_SLICES)
  ) u_column (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .voxel_value (voxel_value),
    .advance     (advance),
    .push        (chain[0])
  );

  // One cell per quotient bit of the 48-bit mean division.
  for (genvar k = 0; k < ACC_W; k++) begin : g_cell
    vap_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .in_cell  (chain[k]),
      .out_cell (chain[k+1])
    );
  end

  assign tail = chain[ACC_W];

  // Output register. A mean of a negative sum is negated back here, which
  // gives truncation toward zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      projected_value <= (tail.div && tail.neg) ? -tail.word : tail.word;
      out_x           <= tail.x;
      out_z           <= tail.z;
      volume_done     <= tail.done;
    end
  end

  // The remainder of a finished division must be below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    (tail.valid && tail.div) |-> (tail.rem < tail.dvsr))
    else $error("divider chain remainder not below divisor");

  // A column result only enters the chain on a cycle when the chain moves.
  assert property (@(posedge clk) disable iff (rst)
    chain[0].valid |-> advance)
    else $error("column result pushed while chain is frozen");

  // A word leaving the chain lands in the output register.
  assert property (@(posedge clk) disable iff (rst)
    (tail.valid && advance) |=> out_valid)
    else $error("chain output word lost");

  // No voxel is taken while the previous one is still being folded in.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("voxel accepted during accumulator update");

endmodule
`default_nettype wire

// ----- hdl/vap_div_cell.sv -----
`default_nettype none
module vap_div_cell
  import vap_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire cell_t in_cell,
  output cell_t      out_cell
);

  // One restoring division step: bring down the next dividend bit and
  // subtract the divisor when it fits.
  logic [COL_REG_W:0] trial;
  logic [COL_REG_W:0] diff;
  logic               ge;
  cell_t              out_cell_next;

  assign trial = {in_cell.rem, in_cell.word[ACC_W-1]};
  assign diff  = trial - {1'b0, in_cell.dvsr};
  assign ge    = (trial >= {1'b0, in_cell.dvsr});

  always_comb begin
    out_cell_next = in_cell;
    if (in_cell.div) begin
      out_cell_next.rem  = ge ? diff[COL_REG_W-1:0] : trial[COL_REG_W-1:0];
      out_cell_next.word = {in_cell.word[ACC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cell.valid <= 1'b0;
    end else if (en) begin
      out_cell <= out_cell_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/vap_column_unit.sv -----
`default_nettype none
module vap_column_unit
  import vap_pkg::*;
#(
  parameter int MAX_ROW    = 1024,
  parameter int MAX_COLUMN = 4096,
  parameter int MAX_SLICES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [VOX_W-1:0]  voxel_value,
  input  wire logic              advance,
  output cell_t                  push
);

  // Position counters only need to reach what the size registers can hold.
  localparam int ROW_LIM = (MAX_ROW < 2047) ? MAX_ROW : 2047;
  localparam int COL_LIM = (MAX_COLUMN < 8191) ? MAX_COLUMN : 8191;
  localparam int SLC_LIM = (MAX_SLICES < 8191) ? MAX_SLICES : 8191;
  localparam int XW = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
  localparam int YW = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
  localparam int ZW = (SLC_LIM > 1) ? $clog2(SLC_LIM) : 1;
  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t            state;
  logic [XW-1:0]     x_pos;
  logic [YW-1:0]     y_pos;
  logic [ZW-1:0]     z_pos;
  logic [VOX_W-1:0]  vox;
  logic [ACC_W-1:0]  acc_rd;
  logic [ACC_W-1:0]  acc_mem [MAX_ROW];

  logic [SIZE_W-1:0]         nx, ny, nz;
  logic                      last_x, last_y, last_z;
  logic                      accept, commit;
  logic [XW+AW-1:0]          x_wide_addr;
  logic [AW-1:0]             addr;
  logic [XW+OUT_X_W-1:0]     x_wide_out;
  logic [ZW+OUT_Z_W-1:0]     z_wide_out;
  logic [ACC_W-1:0]          vox_ext;
  logic [ACC_W-1:0]          acc_new;

  assign nx = clamp_size(SIZE_W'(cfg.row_length), SIZE_W'(MAX_ROW));
  assign ny = clamp_size(SIZE_W'(cfg.column_height), SIZE_W'(MAX_COLUMN));
  assign nz = clamp_size(SIZE_W'(cfg.slice_count), SIZE_W'(MAX_SLICES));

  assign last_x = (SIZE_W'(x_pos) + SIZE_W'(1)) >= nx;
  assign last_y = (SIZE_W'(y_pos) + SIZE_W'(1)) >= ny;
  assign last_z = (SIZE_W'(z_pos) + SIZE_W'(1)) >= nz;

  assign x_wide_addr = {{AW{1'b0}}, x_pos};
  assign addr        = x_wide_addr[AW-1:0];
  assign x_wide_out  = {{OUT_X_W{1'b0}}, x_pos};
  assign z_wide_out  = {{OUT_Z_W{1'b0}}, z_pos};

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // A column's last word waits here until the divider chain can take it.
  assign commit   = (state == ST_UPDATE) && (!last_y || advance);

  assign vox_ext = {{(ACC_W-VOX_W){vox[VOX_W-1]}}, vox};

  always_comb begin
    acc_new = vox_ext;
    if (y_pos != '0) begin
      case (cfg.method)
        METHOD_MAX: acc_new = ($signed(vox_ext) > $signed(acc_rd)) ? vox_ext : acc_rd;
        METHOD_MIN: acc_new = ($signed(vox_ext) < $signed(acc_rd)) ? vox_ext : acc_rd;
        default:    acc_new = acc_rd + vox_ext;
      endcase
    end
  end

  always_comb begin
    push.valid = commit && last_y;
    push.div   = (cfg.method == METHOD_MEAN);
    push.neg   = acc_new[ACC_W-1];
    push.word  = ((cfg.method == METHOD_MEAN) && acc_new[ACC_W-1]) ? -acc_new : acc_new;
    push.rem   = '0;
    push.dvsr  = ny[COL_REG_W-1:0];
    push.x     = x_wide_out[OUT_X_W-1:0];
    push.z     = z_wide_out[OUT_Z_W-1:0];
    push.done  = last_x && last_z;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vox    <= voxel_value;
      acc_rd <= acc_mem[addr];
    end
    if (commit) begin
      acc_mem[addr] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      x_pos <= '0;
      y_pos <= '0;
      z_pos <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (commit) begin
            state <= ST_IDLE;
            if (last_x) begin
              x_pos <= '0;
              if (last_y) begin
                y_pos <= '0;
                z_pos <= last_z ? '0 : z_pos + ZW'(1);
              end else begin
                y_pos <= y_pos + YW'(1);
              end
            end else begin
              x_pos <= x_pos + XW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;
  import vap_pkg::*;

  // Geometry limits of the block as built here.
  localparam int ROW_LIMIT    = 1024;
  localparam int COLUMN_LIMIT = 4096;
  localparam int SLICE_LIMIT  = 4096;

  // A column end reaches the output through the memory read, the update, the
  // divider chain and the output register. Voxels that end no column leave no
  // trace there, so the pipeline drains after the last word before a register write.
  localparam int DRAIN_CYCLES  = 64;
  // Length of a deliberate output stall, long enough to fill the divider chain.
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_VOXELS = 800;
  // Upper bound on the voxel count of one randomly shaped volume.
  localparam int MAX_VOLUME    = 160;

  // One column word as it leaves the block.
  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [OUT_X_W-1:0]      x;
    logic [OUT_Z_W-1:0]      z;
    logic                    done;
  } column_word_t;

  // Scoreboard: keeps its own copy of the registers, the per-x accumulators and
  // the x/y/z position, projects each accepted voxel and queues the column word
  // it must produce. Words from the block are checked against that queue.
  class projection_board;
    method_t                 mode;
    int unsigned             row_len;
    int unsigned             col_height;
    int unsigned             slices;
    logic signed [ACC_W-1:0] column_acc [ROW_LIMIT];
    int unsigned             xpos;
    int unsigned             ypos;
    int unsigned             zpos;
    column_word_t            awaited_columns [$];
    int unsigned             faults;
    int unsigned             words_checked;

    function new();
      mode = METHOD_MAX;
      row_len = 1;
      col_height = 1;
      slices = 1;
      foreach (column_acc[i]) column_acc[i] = '0;
      xpos = 0;
      ypos = 0;
      zpos = 0;
      faults = 0;
      words_checked = 0;
    endfunction

    // A size of zero counts as one, anything past the limit as the limit.
    static function int unsigned fit(int unsigned v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function int unsigned volume_size();
      return fit(row_len, ROW_LIMIT) * fit(col_height, COLUMN_LIMIT) *
             fit(slices, SLICE_LIMIT);
    endfunction

    // Registers keep only their own width of the write data.
    function void set_register(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_METHOD:        mode = method_t'(data[METHOD_W-1:0]);
        REG_ROW_LENGTH:    row_len = data[ROW_REG_W-1:0];
        REG_COLUMN_HEIGHT: col_height = data[COL_REG_W-1:0];
        REG_SLICE_COUNT:   slices = data[SLC_REG_W-1:0];
        default:           ;
      endcase
    endfunction

    function void note_voxel(logic [VOX_W-1:0] raw);
      int unsigned             nx;
      int unsigned             ny;
      int unsigned             nz;
      int unsigned             xi;
      logic signed [ACC_W-1:0] v;
      logic signed [ACC_W-1:0] acc;
      bit                      last_x;
      bit                      last_y;
      bit                      last_z;
      column_word_t            w;
      nx = fit(row_len, ROW_LIMIT);
      ny = fit(col_height, COLUMN_LIMIT);
      nz = fit(slices, SLICE_LIMIT);
      v = {{(ACC_W - VOX_W){raw[VOX_W-1]}}, raw};
      xi = xpos % ROW_LIMIT;
      acc = column_acc[xi];
      // A position at or past its last index counts as the last one, which
      // is what a register shrunk in the middle of a volume relies on.
      last_x = (xpos + 1 >= nx);
      last_y = (ypos + 1 >= ny);
      last_z = (zpos + 1 >= nz);
      if (ypos == 0) begin
        acc = v;
      end else begin
        case (mode)
          METHOD_MAX: if (v > acc) acc = v;
          METHOD_MIN: if (v < acc) acc = v;
          default:    acc = acc + v;
        endcase
      end
      column_acc[xi] = acc;
      if (last_y) begin
        // The mean divides the signed sum and truncates toward zero.
        if (mode == METHOD_MEAN) begin
          w.value = ACC_W'(longint'(acc) / longint'(ny));
        end else begin
          w.value = acc;
        end
        w.x = OUT_X_W'(xpos);
        w.z = OUT_Z_W'(zpos);
        w.done = last_x && last_z;
        awaited_columns.push_back(w);
      end
      if (last_x) begin
        xpos = 0;
        if (last_y) begin
          ypos = 0;
          zpos = last_z ? 0 : zpos + 1;
        end else begin
          ypos++;
        end
      end else begin
        xpos++;
      end
    endfunction

    task flag(string what);
      if (faults < 100) $display("MISMATCH: %s", what);
      faults++;
    endtask

    task check_column(column_word_t got);
      column_word_t want;
      words_checked++;
      if (awaited_columns.size() == 0) begin
        flag($sformatf("word with nothing pending: value %h x %0d z %0d",
                       got.value, got.x, got.z));
        return;
      end
      want = awaited_columns.pop_front();
      if (got.value !== want.value)
        flag($sformatf("value %h, want %h (x %0d z %0d)",
                       got.value, want.value, want.x, want.z));
      if (got.x !== want.x)
        flag($sformatf("out_x %0d, want %0d", got.x, want.x));
      if (got.z !== want.z)
        flag($sformatf("out_z %0d, want %0d", got.z, want.z));
      if (got.done !== want.done)
        flag($sformatf("volume_done %b, want %b (x %0d z %0d)",
                       got.done, want.done, want.x, want.z));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VOX_W-1:0]      voxel_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ACC_W-1:0]      projected_value;
  logic [OUT_X_W-1:0]    out_x;
  logic [OUT_Z_W-1:0]    out_z;
  logic                  volume_done;

  projection_board board = new();

  // When calm is set, neither side inserts any gap.
  bit          calm = 1'b0;
  // Set by the hold process while the receiver must keep out_ready low.
  bit          holding = 1'b0;
  int unsigned voxels_in = 0;
  int unsigned settings = 0;

  volume_axis_projection_core #(
    .MAX_ROW    (ROW_LIMIT),
    .MAX_COLUMN (COLUMN_LIMIT),
    .MAX_SLICES (SLICE_LIMIT)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .voxel_value     (voxel_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .projected_value (projected_value),
    .out_x           (out_x),
    .out_z           (out_z),
    .volume_done     (volume_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Voxels: full-range random, small values around zero so that mean
  // truncation shows, and the Q16.16 extremes.
  function automatic logic [VOX_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 5))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        4:       return 32'h0001_0000;
        default: return 32'hFFFF_0000;
      endcase
    end
    if (r < 35) return VOX_W'($urandom_range(0, 1023)) - 32'd512;
    return $urandom;
  endfunction

  // Mostly small sizes, sometimes a larger one, now and then a zero.
  function automatic int unsigned pick_size(int unsigned common, int unsigned rare);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 17) return $urandom_range(1, common);
    return $urandom_range(1, rare);
  endfunction

  // Fill the data bits above a register's width with noise; the block must
  // drop them.
  function automatic logic [CFG_DATA_W-1:0] dress(reg_index_t idx, int unsigned val);
    logic [CFG_DATA_W-1:0] keep;
    case (idx)
      REG_METHOD:     keep = CFG_DATA_W'((1 << METHOD_W) - 1);
      REG_ROW_LENGTH: keep = CFG_DATA_W'((1 << ROW_REG_W) - 1);
      default:        keep = '1;
    endcase
    return (CFG_DATA_W'(val) & keep) | (CFG_DATA_W'($urandom) & ~keep);
  endfunction

  // Offer one voxel after an optional gap and hold it until it is taken.
  task automatic send_voxel(logic [VOX_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    voxel_value = val;
    do @(posedge clk); while (!in_ready);
    board.note_voxel(val);
    voxels_in++;
  endtask

  // Stop offering voxels, let every pending word arrive, then give the
  // pipeline time to retire voxels that end no column.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.awaited_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    board.set_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(method_t m, int unsigned nx, int unsigned ny,
                           int unsigned nz);
    settle();
    write_reg(REG_METHOD, dress(REG_METHOD, m));
    write_reg(REG_ROW_LENGTH, dress(REG_ROW_LENGTH, nx));
    write_reg(REG_COLUMN_HEIGHT, dress(REG_COLUMN_HEIGHT, ny));
    write_reg(REG_SLICE_COUNT, dress(REG_SLICE_COUNT, nz));
    settings++;
  endtask

  task automatic send_volume();
    int unsigned n;
    n = board.volume_size();
    repeat (n) send_voxel(pick_value());
  endtask

  task automatic hold_output();
    @(posedge clk);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  endtask

  // Receiver: decides out_ready at each falling edge, samples at the rising
  // edge and hands every accepted word to the scoreboard.
  initial begin : receiver
    int unsigned  stall;
    column_word_t got;
    stall = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (holding || stall > 0) begin
        out_ready = 1'b0;
        if (!holding) stall--;
      end else begin
        out_ready = 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.value = projected_value;
        got.x = out_x;
        got.z = out_z;
        got.done = volume_done;
        board.check_column(got);
        stall = pick_gap();
      end
    end
  end

  // Two long output stalls while the sender keeps offering: the first inside
  // the full-width row, where every voxel ends a column, the second during
  // the random volumes. The chain fills and the input must back up.
  initial begin : long_hold
    wait (voxels_in >= 500);
    hold_output();
    wait (voxels_in >= 1400);
    hold_output();
  end

  initial begin : watchdog
    #(64'd12_000_000);
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    method_t     m;
    int unsigned nx;
    int unsigned ny;
    int unsigned nz;
    int unsigned start;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Registers at reset: maximum over single-voxel columns, so each voxel
    // comes straight back, sign-extended, and closes the volume.
    send_voxel(32'h7FFF_FFFF);
    send_voxel(32'h8000_0000);
    send_voxel(32'h0000_0000);
    send_voxel(32'hFFFF_FFFF);

    // Minimum over 2x2 columns with the extreme values on both sides.
    configure(METHOD_MIN, 2, 2, 1);
    send_voxel(32'h7FFF_FFFF);
    send_voxel(32'h8000_0000);
    send_voxel(32'hFFFF_FFFF);
    send_voxel(32'h7FFF_FFFF);

    // Method changed inside one column: max, then sum, then the mean closes
    // it and divides everything gathered so far by the height.
    configure(METHOD_MAX, 1, 3, 1);
    send_voxel(32'h0001_0000);
    settle();
    write_reg(REG_METHOD, dress(REG_METHOD, METHOD_SUM));
    send_voxel(32'hFFFF_8000);
    settle();
    write_reg(REG_METHOD, dress(REG_METHOD, METHOD_MEAN));
    send_voxel(32'h0000_0003);

    // Geometry shrunk mid-volume: the column height drops below the current
    // y, so the next row closes the columns; then the slice count drops
    // below the current z, so that slice ends the volume.
    configure(METHOD_MEAN, 2, 4, 2);
    send_voxel(-32'sd5);
    send_voxel(32'sd7);
    send_voxel(-32'sd8);
    send_voxel(-32'sd1);
    settle();
    write_reg(REG_COLUMN_HEIGHT, dress(REG_COLUMN_HEIGHT, 2));
    send_voxel(-32'sd1);
    send_voxel(-32'sd2);
    settle();
    write_reg(REG_SLICE_COUNT, dress(REG_SLICE_COUNT, 1));
    send_voxel(-32'sd3);
    send_voxel(32'sd9);
    send_voxel(-32'sd4);
    send_voxel(32'h8000_0000);

    // Zero sizes act as one.
    configure(METHOD_SUM, 0, 0, 0);
    send_voxel(32'h7FFF_FFFF);
    send_voxel(32'h8000_0000);

    // Limit: a row past the maximum width wraps at the maximum and closes
    // the volume there.
    calm = 1'b0;
    configure(method_t'($urandom_range(0, 3)), 2047, 1, 1);
    send_volume();

    // Random volumes of mostly small shapes, some phases without any gaps.
    start = voxels_in;
    while (voxels_in - start < RANDOM_VOXELS) begin
      m = method_t'($urandom_range(0, 3));
      nx = pick_size(12, 64);
      ny = pick_size(6, 32);
      nz = pick_size(3, 3);
      while (projection_board::fit(nx, ROW_LIMIT) * projection_board::fit(ny, COLUMN_LIMIT) *
             projection_board::fit(nz, SLICE_LIMIT) > MAX_VOLUME) begin
        if (nz > 1) nz = 1;
        else ny = ny / 2;
      end
      configure(m, nx, ny, nz);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) send_volume();
    end

    calm = 1'b0;
    settle();
    $display("Run fed %0d voxels through %0d register settings; %0d column words checked.",
             voxels_in, settings, board.words_checked);
    $display("It covered all four methods, zero and oversize row sizes, the row width");
    $display("limit, register changes inside a volume and long output stalls.");
    if (board.faults == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", board.faults);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
